@@ hdl/gida_pkg.sv @@
// ----------------------------------------------------------------------------
// gida_pkg
// Shared field widths, request and status codes, and the bit-search result
// type of the generational ID allocator.
// ----------------------------------------------------------------------------
package gida_pkg;

   // field widths
   localparam int KIND_W      = 2;
   localparam int ID_W        = 10;
   localparam int GEN_W       = 16;
   localparam int STAT_W      = 2;
   localparam int LO_W        = 10;
   localparam int HI_W        = 11;

   // scan positions and bitmap words
   localparam int POS_W       = 11;
   localparam int WORD_W      = 32;
   localparam int WORD_SH     = 5;
   localparam int WIDX_W      = POS_W - WORD_SH;

   // port widths
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 11;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOT_LIVE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH = 1'b1;

   // outcome of a search for a free bit in one bitmap word
   typedef struct packed {
      logic               hit;
      logic [WORD_SH-1:0] pos;
   } find_type;

endpackage

@@ hdl/generational_id_allocator_core.sv @@
// ----------------------------------------------------------------------------
// generational_id_allocator_core
// Hands out handles of ID and 16-bit generation, releases them and checks
// them. Live bits sit in a bitmap memory of 32-bit words, generations in a
// memory of one entry per ID.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake             payload
// req_     in   req_tvalid/tready     tuser kind, tdata id + generation
// rsp_     out  rsp_tvalid/tready     tuser status, tdata id + gen + alive
// csr_     in   csr_valid/csr_ready   csr_index register, csr_data value
//
// release, check, unused kind: S_GWAIT, S_APPLY, S_OUT; allocate: S_SETUP, then
// S_LWAIT and S_EXAM per bitmap word scanned (at most 33 for 1024 IDs), then S_GWAIT,
// S_APPLY, S_OUT (to S_OUT directly when the range is full); after reset both memories
// are cleared with req_tready low; csr writes are taken at any time.
// one item at a time; the next is taken the cycle after its result enters the rsp_
// register, and a finished item stalls only while that register is still full.
//
module generational_id_allocator_core #(
   parameter int ID_COUNT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [9:0] entity_id, [25:10] entity_generation, [31:26] zero
   input  logic [gida_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [gida_pkg::KIND_W-1:0]        req_tuser,

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] result_id, [25:10] result_generation, [26] alive, [31:27] zero
   output logic [gida_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic [gida_pkg::STAT_W-1:0]        rsp_tuser,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gida_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gida_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int IW    = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
   localparam int WORDS = (ID_COUNT + gida_pkg::WORD_W - 1) / gida_pkg::WORD_W;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [16:0] ID_LIMIT = 17'(ID_COUNT);
   localparam logic [IW-1:0] CLR_LAST = IW'(ID_COUNT - 1);

   // sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_LWAIT = 3'd3;
   localparam logic [2:0] S_EXAM  = 3'd4;
   localparam logic [2:0] S_GWAIT = 3'd5;
   localparam logic [2:0] S_APPLY = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   // control registers
   logic [2:0]                     state_ff, state_in;
   logic [IW-1:0]                  clr_ff, clr_in;
   logic                           phase_ff, phase_in;
   logic [gida_pkg::ID_W-1:0]      cursor_ff, cursor_in;
   logic [gida_pkg::LO_W-1:0]      range_low_ff;
   logic [gida_pkg::HI_W-1:0]      range_high_ff;
   logic                           rsp_valid_ff, rsp_valid_in;

   // item and scan registers
   logic [gida_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [gida_pkg::ID_W-1:0]      id_ff, id_in;
   logic [gida_pkg::GEN_W-1:0]     gen_ff, gen_in;
   logic [gida_pkg::WIDX_W-1:0]    word_ff, word_in;
   logic [gida_pkg::POS_W-1:0]     lo_ff, lo_in;
   logic [gida_pkg::POS_W-1:0]     c_ff, c_in;
   logic [gida_pkg::POS_W-1:0]     win_lo_ff, win_lo_in;
   logic [gida_pkg::POS_W-1:0]     win_hi_ff, win_hi_in;

   // pending result and output register
   logic [gida_pkg::ID_W-1:0]      res_id_ff, res_id_in;
   logic [gida_pkg::GEN_W-1:0]     res_gen_ff, res_gen_in;
   logic [gida_pkg::STAT_W-1:0]    res_st_ff, res_st_in;
   logic                           res_alive_ff, res_alive_in;
   logic [gida_pkg::ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [gida_pkg::GEN_W-1:0]     rsp_gen_ff, rsp_gen_in;
   logic [gida_pkg::STAT_W-1:0]    rsp_st_ff, rsp_st_in;
   logic                           rsp_alive_ff, rsp_alive_in;

   // memory ports
   logic                           live_we;
   logic [WAW-1:0]                 live_waddr, live_raddr;
   logic [gida_pkg::WORD_W-1:0]    live_wdata, live_q;
   logic                           gen_we;
   logic [IW-1:0]                  gen_waddr, gen_raddr;
   logic [gida_pkg::GEN_W-1:0]     gen_wdata, gen_q;

   // address helpers
   logic [16:0]                    id_wide, word_wide, clr_wide, clr_word_wide;
   logic                           id_ok;
   logic [gida_pkg::POS_W-1:0]     base;
   logic [gida_pkg::POS_W:0]       word_end;
   logic [gida_pkg::POS_W-1:0]     range_lo, range_hi, start_pos;
   logic [gida_pkg::POS_W-1:0]     hit_pos;
   logic [gida_pkg::WORD_W-1:0]    hit_mask, id_mask;
   logic [gida_pkg::GEN_W-1:0]     stored_gen;
   logic                           stored_live;
   gida_pkg::find_type             find;

   assign id_wide       = 17'(id_ff);
   assign word_wide     = 17'(word_ff);
   assign clr_wide      = 17'(clr_ff);
   assign clr_word_wide = clr_wide >> gida_pkg::WORD_SH;
   assign id_ok         = id_wide < ID_LIMIT;

   assign base     = {word_ff, {gida_pkg::WORD_SH{1'b0}}};
   assign word_end = {1'b0, base} + (gida_pkg::POS_W + 1)'(gida_pkg::WORD_W);
   assign hit_pos  = {word_ff, find.pos};
   assign hit_mask = gida_pkg::WORD_W'(1) << find.pos;
   assign id_mask  = gida_pkg::WORD_W'(1) << id_ff[gida_pkg::WORD_SH-1:0];

   // allocatable range, high end clamped to the store
   assign range_lo = gida_pkg::POS_W'(range_low_ff);
   assign range_hi = (17'(range_high_ff) < ID_LIMIT) ? range_high_ff
                                                      : ID_LIMIT[gida_pkg::POS_W-1:0];
   assign start_pos = (gida_pkg::POS_W'(cursor_ff) >= range_lo &&
                       gida_pkg::POS_W'(cursor_ff) <  range_hi)
                      ? gida_pkg::POS_W'(cursor_ff) : range_lo;

   // stored state of the item's ID, IDs beyond the store read as free, zero
   assign stored_gen  = id_ok ? gen_q : '0;
   assign stored_live = id_ok & live_q[id_ff[gida_pkg::WORD_SH-1:0]];

   // memory addresses
   assign live_raddr = word_wide[WAW-1:0];
   assign gen_raddr  = id_wide[IW-1:0];
   assign live_waddr = (state_ff == S_CLEAR) ? clr_word_wide[WAW-1:0] : word_wide[WAW-1:0];
   assign gen_waddr  = (state_ff == S_CLEAR) ? clr_ff : id_wide[IW-1:0];

   gida_ram #(
      .DEPTH (WORDS),
      .WIDTH (gida_pkg::WORD_W),
      .AW    (WAW)
   ) u_live_ram (
      .clock   (clock),
      .wr_en   (live_we),
      .wr_addr (live_waddr),
      .wr_data (live_wdata),
      .rd_addr (live_raddr),
      .rd_data (live_q)
   );

   gida_ram #(
      .DEPTH (ID_COUNT),
      .WIDTH (gida_pkg::GEN_W),
      .AW    (IW)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (gen_waddr),
      .wr_data (gen_wdata),
      .rd_addr (gen_raddr),
      .rd_data (gen_q)
   );

   gida_find u_find (
      .live_word (live_q),
      .base      (base),
      .win_lo    (win_lo_ff),
      .win_hi    (win_hi_ff),
      .result    (find)
   );

   // handshakes and output packing
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_alive_ff, rsp_gen_ff, rsp_id_ff};
   assign rsp_tuser  = rsp_st_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      phase_in     = phase_ff;
      cursor_in    = cursor_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      gen_in       = gen_ff;
      word_in      = word_ff;
      lo_in        = lo_ff;
      c_in         = c_ff;
      win_lo_in    = win_lo_ff;
      win_hi_in    = win_hi_ff;
      res_id_in    = res_id_ff;
      res_gen_in   = res_gen_ff;
      res_st_in    = res_st_ff;
      res_alive_in = res_alive_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_gen_in   = rsp_gen_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_alive_in = rsp_alive_ff;
      live_we      = 1'b0;
      live_wdata   = live_q;
      gen_we       = 1'b0;
      gen_wdata    = stored_gen + gida_pkg::GEN_W'(1);

      case (state_ff)
         // clearing pass over both memories
         S_CLEAR: begin
            live_we    = 1'b1;
            live_wdata = '0;
            gen_we     = 1'b1;
            gen_wdata  = '0;
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + IW'(1);
            end
         end

         // take one request beat
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               id_in   = req_tdata[gida_pkg::ID_W-1:0];
               gen_in  = req_tdata[gida_pkg::ID_W +: gida_pkg::GEN_W];
               word_in = gida_pkg::WIDX_W'(req_tdata[gida_pkg::ID_W-1:0] >> gida_pkg::WORD_SH);
               if (req_tuser == gida_pkg::KIND_ALLOC) begin
                  state_in = S_SETUP;
               end else begin
                  state_in = S_GWAIT;
               end
            end
         end

         // open the first scan window at the cursor
         S_SETUP: begin
            res_alive_in = 1'b0;
            if (range_lo >= range_hi) begin
               res_id_in  = '0;
               res_gen_in = '0;
               res_st_in  = gida_pkg::STAT_FULL;
               state_in   = S_OUT;
            end else begin
               lo_in     = range_lo;
               c_in      = start_pos;
               win_lo_in = start_pos;
               win_hi_in = range_hi;
               phase_in  = 1'b0;
               word_in   = start_pos[gida_pkg::POS_W-1:gida_pkg::WORD_SH];
               state_in  = S_LWAIT;
            end
         end

         // bitmap word read in flight
         S_LWAIT: begin
            state_in = S_EXAM;
         end

         // search the word, claim a hit or move on
         S_EXAM: begin
            if (find.hit) begin
               live_we    = 1'b1;
               live_wdata = live_q | hit_mask;
               id_in      = hit_pos[gida_pkg::ID_W-1:0];
               cursor_in  = hit_pos[gida_pkg::ID_W-1:0];
               state_in   = S_GWAIT;
            end else if (word_end >= {1'b0, win_hi_ff}) begin
               if (!phase_ff && (lo_ff < c_ff)) begin
                  // wrap to the part of the range below the start
                  phase_in  = 1'b1;
                  win_lo_in = lo_ff;
                  win_hi_in = c_ff;
                  word_in   = lo_ff[gida_pkg::POS_W-1:gida_pkg::WORD_SH];
                  state_in  = S_LWAIT;
               end else begin
                  res_id_in    = '0;
                  res_gen_in   = '0;
                  res_st_in    = gida_pkg::STAT_FULL;
                  res_alive_in = 1'b0;
                  state_in     = S_OUT;
               end
            end else begin
               word_in  = word_ff + gida_pkg::WIDX_W'(1);
               state_in = S_LWAIT;
            end
         end

         // generation read in flight
         S_GWAIT: begin
            state_in = S_APPLY;
         end

         // update the entry and form the result
         S_APPLY: begin
            res_id_in    = id_ff;
            res_gen_in   = stored_gen;
            res_st_in    = gida_pkg::STAT_OK;
            res_alive_in = 1'b0;
            case (kind_ff)
               gida_pkg::KIND_ALLOC: begin
                  res_gen_in = gen_q;
               end
               gida_pkg::KIND_RELEASE: begin
                  if (stored_live) begin
                     live_we    = 1'b1;
                     live_wdata = live_q & ~id_mask;
                     gen_we     = 1'b1;
                     res_gen_in = gen_wdata;
                  end else begin
                     res_st_in = gida_pkg::STAT_NOT_LIVE;
                  end
               end
               gida_pkg::KIND_CHECK: begin
                  res_alive_in = (stored_gen == gen_ff);
               end
               default: begin
                  res_gen_in = stored_gen;
               end
            endcase
            state_in = S_OUT;
         end

         // hand the result to the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_gen_in   = res_gen_ff;
               rsp_st_in    = res_st_ff;
               rsp_alive_in = res_alive_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         phase_ff     <= 1'b0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         phase_ff     <= phase_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // range registers, written by csr beats
   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= '0;
         range_high_ff <= gida_pkg::HI_W'(1024);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gida_pkg::CSR_RANGE_LOW:  range_low_ff  <= csr_data[gida_pkg::LO_W-1:0];
            gida_pkg::CSR_RANGE_HIGH: range_high_ff <= csr_data[gida_pkg::HI_W-1:0];
            default: ;
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      id_ff        <= id_in;
      gen_ff       <= gen_in;
      word_ff      <= word_in;
      lo_ff        <= lo_in;
      c_ff         <= c_in;
      win_lo_ff    <= win_lo_in;
      win_hi_ff    <= win_hi_in;
      res_id_ff    <= res_id_in;
      res_gen_ff   <= res_gen_in;
      res_st_ff    <= res_st_in;
      res_alive_ff <= res_alive_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_gen_ff   <= rsp_gen_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_alive_ff <= rsp_alive_in;
   end

endmodule

@@ hdl/gida_ram.sv @@
// ----------------------------------------------------------------------------
// gida_ram
// Single-port-write, single-port-read synchronous memory with registered
// read data.
// ----------------------------------------------------------------------------
module gida_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/gida_find.sv @@
// ----------------------------------------------------------------------------
// gida_find
// Finds the lowest free ID of one live-bitmap word that lies inside the
// scan window [win_lo, win_hi).
// ----------------------------------------------------------------------------
module gida_find (
   input  logic [gida_pkg::WORD_W-1:0] live_word,
   input  logic [gida_pkg::POS_W-1:0]  base,
   input  logic [gida_pkg::POS_W-1:0]  win_lo,
   input  logic [gida_pkg::POS_W-1:0]  win_hi,
   output gida_pkg::find_type          result
);

   logic [gida_pkg::WORD_W-1:0] free_bits;
   logic [gida_pkg::POS_W:0]    pos_val;

   // free and inside the window, one bit at a time
   always_comb begin
      pos_val = '0;
      for (int k = 0; k < gida_pkg::WORD_W; k++) begin
         pos_val = {1'b0, base} + (gida_pkg::POS_W + 1)'(k);
         free_bits[k] = ~live_word[k]
                        && (pos_val >= {1'b0, win_lo})
                        && (pos_val <  {1'b0, win_hi});
      end
   end

   // priority encode, lowest position wins
   always_comb begin
      result.hit = 1'b0;
      result.pos = '0;
      for (int k = gida_pkg::WORD_W - 1; k >= 0; k--) begin
         if (free_bits[k]) begin
            result.hit = 1'b1;
            result.pos = gida_pkg::WORD_SH'(k);
         end
      end
   end

endmodule

@@ tb/generational_id_allocator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// generational_id_allocator_core_tb
// Self-checking bench for the generational ID allocator. A behavioral model
// of the live bitmap, generation store and scan cursor predicts every
// response beat. Directed requests cover the range edges first, then random
// handle traffic runs under varying stalls and receiver back-pressure.
// ----------------------------------------------------------------------------
module generational_id_allocator_core_tb;

   localparam int ID_COUNT     = 1024;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 300;
   localparam int PRINT_LIMIT  = 50;

   // kind code with no function in the block
   localparam logic [gida_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [gida_pkg::ID_W-1:0]   id;
      logic [gida_pkg::GEN_W-1:0]  gen;
      logic [gida_pkg::STAT_W-1:0] status;
      logic                        alive;
   } handle_result_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [gida_pkg::REQ_TDATA_W-1:0]    req_tdata;
   logic [gida_pkg::KIND_W-1:0]         req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [gida_pkg::RSP_TDATA_W-1:0]    rsp_tdata;
   logic [gida_pkg::STAT_W-1:0]         rsp_tuser;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [gida_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [gida_pkg::CSR_DATA_W-1:0]     csr_data;

   // model of the allocator state and range registers
   logic                                live_q [ID_COUNT];
   logic [gida_pkg::GEN_W-1:0]          gen_q  [ID_COUNT];
   logic [gida_pkg::ID_W-1:0]           cursor_q;
   logic [gida_pkg::LO_W-1:0]           range_lo_q;
   logic [gida_pkg::HI_W-1:0]           range_hi_q;

   handle_result_type       pending_results [$];
   handle_result_type       last_result;

   int snd_idle_pct;
   int rcv_idle_pct;
   int hold_req;
   int mismatches;
   int n_items, n_alloc_ok, n_full, n_release_ok, n_not_live;
   int n_checks, n_alive, n_unused, n_csr;

   generational_id_allocator_core #(
      .ID_COUNT (ID_COUNT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // next response for one request, updating the model state
   function automatic handle_result_type predict_handle(
      input logic [gida_pkg::KIND_W-1:0] kind,
      input logic [gida_pkg::ID_W-1:0]   id,
      input logic [gida_pkg::GEN_W-1:0]  gen);
      handle_result_type r;
      int             lo;
      int             hi;
      int             cur;
      int             n;
      logic           found;
      r.id     = id;
      r.gen    = gen_q[id];
      r.status = gida_pkg::STAT_OK;
      r.alive  = 1'b0;
      case (kind)
         gida_pkg::KIND_ALLOC: begin
            lo    = int'(range_lo_q);
            hi    = (range_hi_q < ID_COUNT) ? int'(range_hi_q) : ID_COUNT;
            found = 1'b0;
            cur   = lo;
            if (lo < hi) begin
               // scan starts at the cursor, or at the range base if outside
               cur = (cursor_q < lo || cursor_q >= hi) ? lo : int'(cursor_q);
               for (n = 0; n < hi - lo && !found; n++) begin
                  if (!live_q[cur]) begin
                     found = 1'b1;
                  end else begin
                     cur++;
                     if (cur >= hi) cur = lo;
                  end
               end
            end
            if (found) begin
               live_q[cur] = 1'b1;
               cursor_q    = gida_pkg::ID_W'(cur);
               r.id        = gida_pkg::ID_W'(cur);
               r.gen       = gen_q[cur];
               n_alloc_ok++;
            end else begin
               r.id     = '0;
               r.gen    = '0;
               r.status = gida_pkg::STAT_FULL;
               n_full++;
            end
         end
         gida_pkg::KIND_RELEASE: begin
            if (live_q[id]) begin
               live_q[id] = 1'b0;
               gen_q[id]  = gen_q[id] + 1'b1;
               r.gen      = gen_q[id];
               n_release_ok++;
            end else begin
               r.status = gida_pkg::STAT_NOT_LIVE;
               n_not_live++;
            end
         end
         gida_pkg::KIND_CHECK: begin
            r.alive = (gen_q[id] == gen);
            n_checks++;
            if (r.alive) n_alive++;
         end
         default: begin
            n_unused++;
         end
      endcase
      return r;
   endfunction

   // offer one request beat, predict it once accepted
   task automatic send_item(input logic [gida_pkg::KIND_W-1:0] kind,
                            input logic [gida_pkg::ID_W-1:0]   id,
                            input logic [gida_pkg::GEN_W-1:0]  gen);
      if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(gida_pkg::REQ_TDATA_W - gida_pkg::ID_W - gida_pkg::GEN_W){1'b0}},
                     gen, id};
      do @(posedge clock); while (!req_tready);
      last_result = predict_handle(kind, id, gen);
      pending_results.push_back(last_result);
      n_items++;
   endtask

   // stop offering and wait until every response is back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic [gida_pkg::CSR_IDX_W-1:0]  index,
                            input logic [gida_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == gida_pkg::CSR_RANGE_LOW) range_lo_q = value[gida_pkg::LO_W-1:0];
      else                                  range_hi_q = value[gida_pkg::HI_W-1:0];
      n_csr++;
      @(posedge clock);
   endtask

   // change the allocatable range while the block is idle
   task automatic set_range(input logic [gida_pkg::LO_W-1:0] lo,
                            input logic [gida_pkg::HI_W-1:0] hi);
      settle();
      write_csr(gida_pkg::CSR_RANGE_LOW, gida_pkg::CSR_DATA_W'(lo));
      write_csr(gida_pkg::CSR_RANGE_HIGH, gida_pkg::CSR_DATA_W'(hi));
   endtask

   // allocate, release, check and the unused kind on the reset range
   task automatic test_basics();
      send_item(gida_pkg::KIND_ALLOC, 10'h3FF, 16'hFFFF);
      send_item(gida_pkg::KIND_ALLOC, 10'h000, 16'h0000);
      send_item(gida_pkg::KIND_CHECK, 10'd0, 16'h0000);
      send_item(gida_pkg::KIND_CHECK, 10'd1, 16'hFFFF);
      send_item(gida_pkg::KIND_RELEASE, 10'd0, 16'h0000);
      // second release of the same ID is flagged
      send_item(gida_pkg::KIND_RELEASE, 10'd0, 16'h0000);
      // check on a freed ID compares generations only
      send_item(gida_pkg::KIND_CHECK, 10'd0, 16'h0001);
      send_item(KIND_UNUSED, 10'h3FF, 16'hFFFF);
      send_item(gida_pkg::KIND_RELEASE, 10'h3FF, 16'hFFFF);
      send_item(gida_pkg::KIND_CHECK, 10'h3FF, 16'h0000);
      send_item(gida_pkg::KIND_ALLOC, 10'h155, 16'hAAAA);
   endtask

   // clamped top, full range, empty ranges and cursor outside the range
   task automatic test_range_edges();
      int i;
      set_range(10'd1020, 11'd2047);
      for (i = 0; i < 5; i++) send_item(gida_pkg::KIND_ALLOC, 10'd0, 16'h0000);
      send_item(gida_pkg::KIND_RELEASE, 10'd1022, 16'h0000);
      send_item(gida_pkg::KIND_ALLOC, 10'd0, 16'h0000);
      set_range(10'd500, 11'd500);
      send_item(gida_pkg::KIND_ALLOC, 10'd0, 16'h0000);
      set_range(10'd1023, 11'd1);
      send_item(gida_pkg::KIND_ALLOC, 10'd0, 16'h0000);
      set_range(10'd0, 11'd1);
      send_item(gida_pkg::KIND_ALLOC, 10'd0, 16'h0000);
      send_item(gida_pkg::KIND_ALLOC, 10'd0, 16'h0000);
   endtask

   // random handle traffic: mostly well-formed lifecycles, some noise
   task automatic test_random(input int count, input int snd_pct, input int rcv_pct);
      logic [gida_pkg::ID_W-1:0]  handle_ids [$];
      logic [gida_pkg::ID_W-1:0]  id;
      logic [gida_pkg::GEN_W-1:0] gen;
      logic [gida_pkg::LO_W-1:0]  lo;
      logic [gida_pkg::HI_W-1:0]  hi;
      int                         i;
      int                         idx;
      int                         pick;
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      for (i = 0; i < count; i++) begin
         // new range every few dozen beats, often small so it fills up
         if (i % 60 == 0) begin
            lo = ($urandom_range(3) == 0) ? '0 : gida_pkg::LO_W'($urandom_range(1023));
            case ($urandom_range(3))
               0:       hi = gida_pkg::HI_W'(lo) + gida_pkg::HI_W'($urandom_range(8, 1));
               1:       hi = gida_pkg::HI_W'(lo) + gida_pkg::HI_W'($urandom_range(64, 1));
               2:       hi = gida_pkg::HI_W'(ID_COUNT);
               default: hi = gida_pkg::HI_W'($urandom_range(2047));
            endcase
            set_range(lo, hi);
         end
         pick = $urandom_range(99);
         if (pick >= 85) begin
            send_item(gida_pkg::KIND_W'($urandom_range(3)), gida_pkg::ID_W'($urandom),
                      gida_pkg::GEN_W'($urandom));
         end else if (pick < 35 || handle_ids.size() == 0) begin
            send_item(gida_pkg::KIND_ALLOC, gida_pkg::ID_W'($urandom),
                      gida_pkg::GEN_W'($urandom));
            if (last_result.status == gida_pkg::STAT_OK) handle_ids.push_back(last_result.id);
         end else if (pick < 65) begin
            idx = $urandom_range(handle_ids.size() - 1);
            send_item(gida_pkg::KIND_RELEASE, handle_ids[idx], gida_pkg::GEN_W'($urandom));
            handle_ids.delete(idx);
         end else begin
            idx = $urandom_range(handle_ids.size() - 1);
            id  = handle_ids[idx];
            // current, stale or arbitrary generation
            case ($urandom_range(2))
               0:       gen = gen_q[id];
               1:       gen = gen_q[id] - 1'b1;
               default: gen = gida_pkg::GEN_W'($urandom);
            endcase
            send_item(gida_pkg::KIND_CHECK, id, gen);
         end
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      int i;
      set_range(10'd0, gida_pkg::HI_W'(ID_COUNT));
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_req     = HOLD_CYCLES;
      for (i = 0; i < 20; i++)
         send_item(gida_pkg::KIND_ALLOC, gida_pkg::ID_W'($urandom), 16'h0000);
      for (i = 0; i < 20; i++)
         send_item(gida_pkg::KIND_CHECK, gida_pkg::ID_W'(i),
                   gida_pkg::GEN_W'($urandom_range(1)));
   endtask

   // response ready: random stalls, or one long hold when asked
   initial begin : drive_rsp_ready
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            n        = hold_req;
            hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // compare each response beat with the oldest prediction
   always @(posedge clock) begin : check_results
      handle_result_type want;
      handle_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.id     = rsp_tdata[gida_pkg::ID_W-1:0];
         got.gen    = rsp_tdata[gida_pkg::ID_W+gida_pkg::GEN_W-1:gida_pkg::ID_W];
         got.alive  = rsp_tdata[gida_pkg::ID_W+gida_pkg::GEN_W];
         got.status = rsp_tuser;
         if (pending_results.size() == 0) begin
            if (mismatches < PRINT_LIMIT)
               $display("%0t: unexpected beat, expected none, actual id %0d gen %0d status %0d",
                        $time, got.id, got.gen, got.status);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (got.id !== want.id) begin
               if (mismatches < PRINT_LIMIT)
                  $display("%0t: result_id expected %0d actual %0d", $time, want.id, got.id);
               mismatches++;
            end
            if (got.gen !== want.gen) begin
               if (mismatches < PRINT_LIMIT)
                  $display("%0t: result_generation expected %0d actual %0d",
                           $time, want.gen, got.gen);
               mismatches++;
            end
            if (got.status !== want.status) begin
               if (mismatches < PRINT_LIMIT)
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
               mismatches++;
            end
            if (got.alive !== want.alive) begin
               if (mismatches < PRINT_LIMIT)
                  $display("%0t: alive expected %0d actual %0d", $time, want.alive, got.alive);
               mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet = 0;
      else
         quiet++;
      if (quiet >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d responses outstanding",
                  $time, quiet, pending_results.size());
         $display("generational_id_allocator_core_tb: FAIL");
         $finish;
      end
   end

   // test sequence
   initial begin : main
      int i;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      hold_req   = 0;
      mismatches = 0;
      for (i = 0; i < ID_COUNT; i++) begin
         live_q[i] = 1'b0;
         gen_q[i]  = '0;
      end
      cursor_q     = '0;
      range_lo_q   = '0;
      range_hi_q   = gida_pkg::HI_W'(ID_COUNT);
      snd_idle_pct = 35;
      rcv_idle_pct = 48;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basics();
      test_range_edges();
      test_random(350, 35, 48);
      test_random(350, 48, 35);
      test_random(250, 0, 0);
      test_backpressure();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d allocations, %0d range full, %0d releases, %0d not live",
               n_items, n_alloc_ok, n_full, n_release_ok, n_not_live);
      $display("  %0d checks (%0d alive), %0d unused kind, %0d register writes",
               n_checks, n_alive, n_unused, n_csr);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("generational_id_allocator_core_tb: PASS");
      else
         $display("generational_id_allocator_core_tb: FAIL");
      $finish;
   end

endmodule
